@@ rtl/lscd_pkg.sv @@
// lscd_pkg: types, constants and the reciprocal helper function of the line sensor centroid block
// no dependencies; imported by every module under rtl
`default_nettype none

package lscd_pkg;

    localparam int NCH      = 8;
    localparam int SAMPLE_W = 14;
    localparam int CFG_IDX_W = 4;
    localparam int WSUM_W   = 6;
    localparam int CNT_W    = 4;
    localparam int WT_W     = 4;
    localparam int NUM_W    = WSUM_W + 8;
    localparam int RCP_W    = 17;
    localparam int RCP_SHIFT = 16;
    localparam int PROD_W   = NUM_W + RCP_W;
    localparam int POS_W    = 12;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [NCH-1:0][SAMPLE_W-1:0] t_samples;

    // running sums handed from cell to cell
    typedef struct packed {
        logic [NCH-1:0]    bits;
        logic [WSUM_W-1:0] wsum;
        logic [CNT_W-1:0]  cnt;
        logic [WT_W-1:0]   wt;
    } t_acc;

    localparam t_sample THR_RESET [NCH] = '{
        14'd3000, 14'd4500, 14'd5000, 14'd6000,
        14'd7500, 14'd7500, 14'd6000, 14'd3000
    };

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_LEFT  = 2'd1;
    localparam logic [1:0] CLS_RIGHT = 2'd2;
    localparam logic [1:0] CLS_BOTH  = 2'd3;

    localparam logic [NCH-1:0] PAT_LEFT  = 8'h1F;
    localparam logic [NCH-1:0] PAT_RIGHT = 8'hF8;
    localparam logic [NCH-1:0] PAT_BOTH  = 8'hFF;

    // ceil(2^16 / cnt); exact quotient for numerators up to 9216
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lscd_cell.sv @@
// lscd_cell: one channel of the compare chain, holding its own threshold register
// depends on lscd_pkg
`default_nettype none

module lscd_cell
    import lscd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire t_sample  i_cfg_data,
    input  wire t_sample  i_thr_rst,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_samples i_samples,
    input  wire t_acc     i_acc,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_samples      o_samples,
    output t_acc          o_acc
);

    t_sample  r_thr;
    logic     r_valid;
    t_samples r_samples;
    t_acc     r_acc;
    t_acc     n_acc;
    logic     hit;

    assign o_stall = r_valid && i_stall;
    assign hit     = i_samples[0] < r_thr;

    always_comb begin
        n_acc.bits = {hit, i_acc.bits[NCH-1:1]};
        n_acc.wsum = i_acc.wsum + (hit ? WSUM_W'(i_acc.wt) : '0);
        n_acc.cnt  = i_acc.cnt + CNT_W'(hit);
        n_acc.wt   = i_acc.wt + WT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= i_thr_rst;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // next channel moves down to slot zero
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_samples <= {t_sample'(0), i_samples[NCH-1:1]};
            r_acc     <= n_acc;
        end
    end

    assign o_valid   = r_valid;
    assign o_samples = r_samples;
    assign o_acc     = r_acc;

endmodule

`default_nettype wire

@@ rtl/lscd_post.sv @@
// lscd_post: centroid by reciprocal multiply, edge class and output register
// depends on lscd_pkg
`default_nettype none

module lscd_post
    import lscd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_acc i_acc,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [NCH-1:0]   o_line_bits,
    output logic [POS_W-1:0] o_position_q8,
    output logic [1:0]       o_edge_class
);

    logic              r_a_valid;
    logic [PROD_W-1:0] r_a_prod;
    logic [NCH-1:0]    r_a_bits;
    logic              r_b_valid;
    logic [NCH-1:0]    r_b_bits;
    logic [POS_W-1:0]  r_b_pos;
    logic [1:0]        r_b_edge;

    logic              stall_b;
    logic [PROD_W-1:0] n_prod;
    logic [1:0]        n_edge;

    assign stall_b = r_b_valid && i_stall;
    assign o_stall = r_a_valid && stall_b;

    // zero count gives a zero reciprocal, so no line reads as position zero
    assign n_prod = {{RCP_W{1'b0}}, i_acc.wsum, 8'd0}
                  * {{NUM_W{1'b0}}, recip(i_acc.cnt)};

    always_comb begin
        case (r_a_bits)
            PAT_LEFT:  n_edge = CLS_LEFT;
            PAT_RIGHT: n_edge = CLS_RIGHT;
            PAT_BOTH:  n_edge = CLS_BOTH;
            default:   n_edge = CLS_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_a_valid <= i_valid;
            end
            if (!stall_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_a_prod <= n_prod;
            r_a_bits <= i_acc.bits;
        end
        if (r_a_valid && !stall_b) begin
            r_b_bits <= r_a_bits;
            r_b_pos  <= r_a_prod[RCP_SHIFT+POS_W-1:RCP_SHIFT];
            r_b_edge <= n_edge;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_line_bits   = r_b_bits;
    assign o_position_q8 = r_b_pos;
    assign o_edge_class  = r_b_edge;

endmodule

`default_nettype wire

@@ rtl/line_sensor_centroid_edge_top.sv @@
// line_sensor_centroid_edge_top: eight-channel line sensor, threshold, centroid and edge class
// depends on lscd_pkg, lscd_cell, lscd_post
`default_nettype none

// One transaction is a sweep of eight 14-bit samples. Each sample runs through a chain of
// eight compare cells, one per channel, each holding that channel's threshold register;
// a sample strictly below its threshold sets the line bit. Two more stages form the Q8
// centroid (weights 1 to 8, truncated, zero with no bit set) by a reciprocal multiply and
// register the result with its edge class (1 left 0x1F, 2 right 0xF8, 3 all set, else 0).
// A sweep can be taken every cycle unless the chain stalls; each result is registered
// through the eight cells and then the multiply and output stages. Every stage holds
// its transaction only while the stage after it stalls, so bubbles close up. Threshold
// writes (index 0 to 7, higher indexes ignored) take effect at once and belong between
// sweeps, with the block empty.

module line_sensor_centroid_edge_top
    import lscd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SAMPLE_W-1:0]  i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [SAMPLE_W-1:0]  i_sample_0,
    input  wire logic [SAMPLE_W-1:0]  i_sample_1,
    input  wire logic [SAMPLE_W-1:0]  i_sample_2,
    input  wire logic [SAMPLE_W-1:0]  i_sample_3,
    input  wire logic [SAMPLE_W-1:0]  i_sample_4,
    input  wire logic [SAMPLE_W-1:0]  i_sample_5,
    input  wire logic [SAMPLE_W-1:0]  i_sample_6,
    input  wire logic [SAMPLE_W-1:0]  i_sample_7,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [NCH-1:0]            o_line_bits,
    output logic [POS_W-1:0]          o_position_q8,
    output logic [1:0]                o_edge_class
);

    logic     chain_valid   [NCH+1];
    logic     chain_stall   [NCH+1];
    t_samples chain_samples [NCH+1];
    t_acc     chain_acc     [NCH+1];

    assign chain_valid[0]   = i_valid;
    assign o_stall          = chain_stall[0];
    assign chain_samples[0] = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                               i_sample_3, i_sample_2, i_sample_1, i_sample_0};
    assign chain_acc[0]     = '{bits: '0, wsum: '0, cnt: '0, wt: WT_W'(1)};

    for (genvar g = 0; g < NCH; g++) begin : g_cell
        lscd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cfg_we  (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(g))),
            .i_cfg_data(i_cfg_data),
            .i_thr_rst (THR_RESET[g]),
            .i_valid   (chain_valid[g]),
            .o_stall   (chain_stall[g]),
            .i_samples (chain_samples[g]),
            .i_acc     (chain_acc[g]),
            .o_valid   (chain_valid[g+1]),
            .i_stall   (chain_stall[g+1]),
            .o_samples (chain_samples[g+1]),
            .o_acc     (chain_acc[g+1])
        );
    end

    lscd_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (chain_valid[NCH]),
        .o_stall      (chain_stall[NCH]),
        .i_acc        (chain_acc[NCH]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_line_bits  (o_line_bits),
        .o_position_q8(o_position_q8),
        .o_edge_class (o_edge_class)
    );

endmodule

`default_nettype wire

@@ bench/line_sensor_centroid_edge_top_tb.sv @@
// line_sensor_centroid_edge_top_tb: self-checking bench for the eight-channel line sensor block
// drives sweeps through a valid/stall channel, predicts line bits, q8 centroid and edge class
// depends on lscd_pkg and line_sensor_centroid_edge_top
`default_nettype none

module line_sensor_centroid_edge_top_tb;
    import lscd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int IDX_TOP    = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic [NCH-1:0]   bits;
        logic [POS_W-1:0] pos;
        logic [1:0]       cls;
    } t_line_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SAMPLE_W-1:0]  i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [NCH-1:0]       o_line_bits;
    logic [POS_W-1:0]     o_position_q8;
    logic [1:0]           o_edge_class;
    t_samples             bus_sweep = '0;

    t_sample      thr_now [NCH];
    t_samples     pending_sweeps [$];
    t_line_result expected_lines [$];
    logic         sweep_taken = 1'b0;
    logic         no_gaps = 1'b0;
    int           fault_count = 0;
    int           sweeps_sent = 0;
    int           results_checked = 0;
    int           threshold_writes = 0;

    line_sensor_centroid_edge_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_0    (bus_sweep[0]),
        .i_sample_1    (bus_sweep[1]),
        .i_sample_2    (bus_sweep[2]),
        .i_sample_3    (bus_sweep[3]),
        .i_sample_4    (bus_sweep[4]),
        .i_sample_5    (bus_sweep[5]),
        .i_sample_6    (bus_sweep[6]),
        .i_sample_7    (bus_sweep[7]),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_line_bits   (o_line_bits),
        .o_position_q8 (o_position_q8),
        .o_edge_class  (o_edge_class)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t with %0d results outstanding", $realtime, expected_lines.size());
        $display("simulation failed");
        $finish;
    end

    // threshold compare, weighted centroid and pattern class for one sweep
    function automatic t_line_result locate_line(input t_samples sw);
        t_line_result r;
        int           wsum;
        int           cnt;
        r    = '0;
        wsum = 0;
        cnt  = 0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (sw[ch] < thr_now[ch]) begin
                r.bits[ch] = 1'b1;
                wsum += ch + 1;
                cnt++;
            end
        end
        if (cnt != 0) begin
            r.pos = POS_W'((wsum * 256) / cnt);
        end
        case (r.bits)
            PAT_LEFT:  r.cls = CLS_LEFT;
            PAT_RIGHT: r.cls = CLS_RIGHT;
            PAT_BOTH:  r.cls = CLS_BOTH;
            default:   r.cls = CLS_NONE;
        endcase
        return r;
    endfunction

    // samples that land on the wanted side of each threshold, often right at the boundary
    function automatic t_samples make_sweep(input logic [NCH-1:0] want);
        t_samples sw;
        int       thr;
        for (int ch = 0; ch < NCH; ch++) begin
            thr = thr_now[ch];
            if (want[ch] && thr > 0) begin
                sw[ch] = ($urandom_range(3) == 0) ? t_sample'(thr - 1)
                                                  : t_sample'($urandom_range(thr - 1, 0));
            end else begin
                sw[ch] = ($urandom_range(3) == 0) ? t_sample'(thr)
                                                  : t_sample'($urandom_range(SAMPLE_MAX, thr));
            end
        end
        return sw;
    endfunction

    function automatic logic [NCH-1:0] pick_pattern();
        logic [NCH-1:0] p;
        int             len;
        case ($urandom_range(6))
            0:       p = PAT_LEFT;
            1:       p = PAT_RIGHT;
            2:       p = PAT_BOTH;
            3:       p = '0;
            4:       p = NCH'($urandom);
            default: begin
                // a narrow line under one to three adjacent sensors
                len = $urandom_range(3, 1);
                p   = NCH'(((1 << len) - 1) << $urandom_range(NCH - len));
            end
        endcase
        return p;
    endfunction

    task automatic write_threshold(input int idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= SAMPLE_W'(val);
        if (idx < NCH) begin
            thr_now[idx] = t_sample'(val);
        end
        threshold_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        t_samples sw;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    sw[ch] = t_sample'($urandom);
                end
            end else begin
                sw = make_sweep(pick_pattern());
            end
            pending_sweeps.push_back(sw);
        end
    endtask

    // block is empty once every queued sweep is in and every result is out
    task automatic settle();
        while (pending_sweeps.size() != 0 || i_valid || expected_lines.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // sender: next sweep only once the current transaction has gone
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || sweep_taken)) begin
            if (pending_sweeps.size() != 0 && (no_gaps || $urandom_range(99) >= 19)) begin
                bus_sweep <= pending_sweeps.pop_front();
                i_valid   <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !no_gaps && ($urandom_range(99) < 19);
    end

    always @(posedge i_clk) begin
        sweep_taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_lines.push_back(locate_line(bus_sweep));
            sweeps_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_lines.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result bits %02h pos %0d class %0d", $realtime,
                         o_line_bits, o_position_q8, o_edge_class);
            end else begin
                want = expected_lines.pop_front();
                results_checked++;
                if (o_line_bits !== want.bits || o_position_q8 !== want.pos ||
                    o_edge_class !== want.cls) begin
                    fault_count++;
                    $display("%0t: mismatch expected bits %02h pos %0d class %0d, got bits %02h pos %0d class %0d",
                             $realtime, want.bits, want.pos, want.cls,
                             o_line_bits, o_position_q8, o_edge_class);
                end
            end
        end
    end

    initial begin
        t_samples sw;
        thr_now = THR_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed sweeps against the reset thresholds
        pending_sweeps.push_back('0);
        pending_sweeps.push_back('1);
        for (int ch = 0; ch < NCH; ch++) begin
            sw     = '1;
            sw[ch] = t_sample'(thr_now[ch] - 1);
            pending_sweeps.push_back(sw);
        end
        for (int ch = 0; ch < NCH; ch++) begin
            sw[ch] = thr_now[ch];
        end
        pending_sweeps.push_back(sw);
        for (int ch = 0; ch < NCH; ch++) begin
            sw[ch] = t_sample'(thr_now[ch] - 1);
        end
        pending_sweeps.push_back(sw);
        pending_sweeps.push_back(make_sweep(PAT_LEFT));
        pending_sweeps.push_back(make_sweep(PAT_RIGHT));
        pending_sweeps.push_back(make_sweep(8'hFE));
        pending_sweeps.push_back(make_sweep(8'h7F));
        pending_sweeps.push_back(make_sweep(8'h81));
        pending_sweeps.push_back(make_sweep(8'h3F));
        settle();
        queue_random(250);
        settle();

        // every threshold at full scale; writes past the last channel must be dropped
        for (int ch = 0; ch < NCH; ch++) begin
            write_threshold(ch, SAMPLE_MAX);
        end
        for (int idx = NCH; idx <= IDX_TOP; idx++) begin
            write_threshold(idx, 0);
        end
        pending_sweeps.push_back('1);
        pending_sweeps.push_back('0);
        queue_random(150);
        settle();

        // zero thresholds: no channel can ever be set
        for (int ch = 0; ch < NCH; ch++) begin
            write_threshold(ch, 0);
        end
        pending_sweeps.push_back('0);
        queue_random(40);
        settle();

        // random thresholds, back-to-back traffic with no gaps on either side
        for (int ch = 0; ch < NCH; ch++) begin
            write_threshold(ch, $urandom_range(SAMPLE_MAX));
        end
        no_gaps = 1'b1;
        queue_random(300);
        settle();
        no_gaps = 1'b0;

        for (int ch = 0; ch < NCH; ch++) begin
            write_threshold(ch, $urandom_range(SAMPLE_MAX));
        end
        queue_random(300);
        settle();

        // mixed extremes and random values per channel
        for (int ch = 0; ch < NCH; ch++) begin
            case ($urandom_range(2))
                0:       write_threshold(ch, 0);
                1:       write_threshold(ch, SAMPLE_MAX);
                default: write_threshold(ch, $urandom_range(SAMPLE_MAX));
            endcase
        end
        queue_random(300);
        settle();
        repeat (20) @(posedge i_clk);

        if (expected_lines.size() != 0) begin
            fault_count++;
            $display("%0t: %0d expected results never arrived", $realtime, expected_lines.size());
        end
        $display("covered %0d sweeps and %0d checked results over six threshold settings",
                 sweeps_sent, results_checked);
        $display("%0d threshold writes, %0d faults", threshold_writes, fault_count);
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/lscd_pkg.sv
rtl/lscd_cell.sv
rtl/lscd_post.sv
rtl/line_sensor_centroid_edge_top.sv
bench/line_sensor_centroid_edge_top_tb.sv
